// File: hdl/qrs_pkg.sv
// qrs_pkg: shared codes, context type and ordering helpers for the
// quadratic root solver. No dependencies; compile first.
package qrs_pkg;

  localparam logic [2:0] OUTC_INF    = 3'd0;
  localparam logic [2:0] OUTC_NONE   = 3'd1;
  localparam logic [2:0] OUTC_LIN    = 3'd2;
  localparam logic [2:0] OUTC_NOREAL = 3'd3;
  localparam logic [2:0] OUTC_ONE    = 3'd4;
  localparam logic [2:0] OUTC_TWO    = 3'd5;

  localparam int         PERM_CNT    = 6;
  localparam logic [2:0] PERM_LAST   = 3'd5;
  localparam logic [30:0] EPS_RESET  = 31'd66;

  // Context that rides along the solver pipeline with each ordering.
  typedef struct packed {
    logic [2:0]  perm;
    logic        last;
    logic [2:0]  outc;
    logic [31:0] disc;
  } qrs_ctx_t;

  // Which given number sits at coefficient position pos of ordering p.
  function automatic logic [1:0] perm_sel(logic [2:0] p, logic [1:0] pos);
    logic [5:0] t;
    case (p)
      3'd0:    t = 6'b10_01_00;
      3'd1:    t = 6'b01_10_00;
      3'd2:    t = 6'b10_00_01;
      3'd3:    t = 6'b00_10_01;
      3'd4:    t = 6'b01_00_10;
      3'd5:    t = 6'b00_01_10;
      default: t = 6'b10_01_00;
    endcase
    return t[{pos, 1'b0} +: 2];
  endfunction

  // nr[0]: first/second near, nr[1]: first/third near, nr[2]: second/third near.
  function automatic logic pair_near(logic [1:0] x, logic [1:0] y, logic [2:0] nr);
    logic r;
    if (x == y) begin
      r = 1'b1;
    end else if ((x == 2'd2) || (y == 2'd2)) begin
      r = ((x == 2'd0) || (y == 2'd0)) ? nr[1] : nr[2];
    end else begin
      r = nr[0];
    end
    return r;
  endfunction

  // Orderings that survive: drop each one near an earlier surviving ordering.
  function automatic logic [5:0] keep_mask(logic [2:0] nr);
    logic [5:0] skip;
    logic       nb;
    skip = '0;
    for (int i = 0; i < PERM_CNT; i++) begin
      if (!skip[i]) begin
        for (int j = i + 1; j < PERM_CNT; j++) begin
          nb = 1'b1;
          for (int k = 0; k < 3; k++) begin
            if (!pair_near(perm_sel(3'(i), 2'(k)), perm_sel(3'(j), 2'(k)), nr)) begin
              nb = 1'b0;
            end
          end
          if (nb) begin
            skip[j] = 1'b1;
          end
        end
      end
    end
    return ~skip;
  endfunction

endpackage

// File: hdl/qrs_if.sv
// qrs_if: valid/ready channel interfaces for the solver's input numbers
// and its per-ordering results. No dependencies.
interface qrs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coef_first;
  logic signed [31:0] coef_second;
  logic signed [31:0] coef_third;
  modport source (output valid, coef_first, coef_second, coef_third, input ready);
  modport sink   (input valid, coef_first, coef_second, coef_third, output ready);
endinterface

interface qrs_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         perm_index;
  logic [2:0]         outcome;
  logic signed [31:0] root_one;
  logic signed [31:0] root_two;
  logic signed [31:0] discriminant;
  logic               last;
  modport source (output valid, perm_index, outcome, root_one, root_two, discriminant,
                  last, input ready);
  modport sink   (input valid, perm_index, outcome, root_one, root_two, discriminant,
                  last, output ready);
endinterface

// File: hdl/quadratic_root_solver_permutations.sv
// Quadratic solver over the six orderings of three Q-format numbers.
// Throughput: one result per cycle while the output is not stalled; an input
// transaction occupies the issue sequencer until each of its surviving orderings
// (1 to 6) has issued.
// Reset (rst_ni low, asynchronous): pipeline emptied, epsilon back to 66.
// Uses qrs_pkg and the channel interfaces in qrs_if.sv.
module quadratic_root_solver_permutations
  import qrs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  qrs_in_if.sink      in_s,
  qrs_out_if.source   out_m
);

  // Numerator magnitude bits: |-b +/- sqrt| < 2^34, scaled by 2^FRAC_BITS.
  localparam int NM       = 34 + FRAC_BITS;
  localparam int SQ_STEPS = 33;

  localparam logic signed [NM:0] Q_MAX = {{(NM - 30){1'b0}}, {31{1'b1}}};
  localparam logic signed [NM:0] Q_MIN = {{(NM - 30){1'b1}}, {31{1'b0}}};

  function automatic logic [32:0] mag33(logic [32:0] d);
    return d[32] ? (~d + 33'd1) : d;
  endfunction

  function automatic logic [31:0] sat_q(logic signed [NM:0] v);
    logic [31:0] r;
    if (v > Q_MAX) begin
      r = 32'h7fff_ffff;
    end else if (v < Q_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Epsilon register; zero behaves as one.
  // ---------------------------------------------------------------------
  logic [30:0] eps_q;
  logic [30:0] eps_eff;
  logic [32:0] eps33;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  assign eps_eff = (eps_q == '0) ? 31'd1 : eps_q;
  assign eps33   = {2'b00, eps_eff};

  // Global advance: the whole pipeline moves unless the output is held.
  logic adv;
  logic out_vld_q;
  assign adv = !out_vld_q || out_m.ready;

  // ---------------------------------------------------------------------
  // Issue sequencer: hold the three numbers and the mask of orderings still
  // to issue; send the lowest one each cycle the pipeline advances.
  // ---------------------------------------------------------------------
  logic signed [31:0] hv_q [3];
  logic [5:0]         rem_q;
  logic [2:0]         near_in;
  logic [32:0]        dif01, dif02, dif12;
  logic [2:0]         pick;
  logic [5:0]         pick_oh;
  logic               issue;
  logic               is_last;
  logic               in_acc;

  assign dif01 = {in_s.coef_first[31], in_s.coef_first}
               - {in_s.coef_second[31], in_s.coef_second};
  assign dif02 = {in_s.coef_first[31], in_s.coef_first}
               - {in_s.coef_third[31], in_s.coef_third};
  assign dif12 = {in_s.coef_second[31], in_s.coef_second}
               - {in_s.coef_third[31], in_s.coef_third};
  assign near_in = {mag33(dif12) < eps33, mag33(dif02) < eps33, mag33(dif01) < eps33};

  always_comb begin
    pick = 3'd0;
    for (int i = PERM_CNT - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        pick = 3'(i);
      end
    end
  end

  assign pick_oh = 6'b1 << pick;
  assign issue   = adv && (rem_q != '0);
  assign is_last = (rem_q & ~pick_oh) == '0;

  // Take the next transaction once the current one issues its last ordering.
  assign in_s.ready = (rem_q == '0) || (adv && is_last);
  assign in_acc     = in_s.valid && in_s.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (in_acc) begin
      rem_q <= keep_mask(near_in);
    end else if (issue) begin
      rem_q <= rem_q & ~pick_oh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hv_q[0] <= in_s.coef_first;
      hv_q[1] <= in_s.coef_second;
      hv_q[2] <= in_s.coef_third;
    end
  end

  // ---------------------------------------------------------------------
  // P0: ordered coefficients.
  // ---------------------------------------------------------------------
  logic               p0_vld_q;
  logic signed [31:0] p0_a_q, p0_b_q, p0_c_q;
  logic [2:0]         p0_perm_q;
  logic               p0_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q <= 1'b0;
    end else if (adv) begin
      p0_vld_q <= rem_q != '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_a_q    <= hv_q[perm_sel(pick, 2'd0)];
      p0_b_q    <= hv_q[perm_sel(pick, 2'd1)];
      p0_c_q    <= hv_q[perm_sel(pick, 2'd2)];
      p0_perm_q <= pick;
      p0_last_q <= is_last;
    end
  end

  // ---------------------------------------------------------------------
  // P1: squares and products, near-zero tests of the coefficients.
  // ---------------------------------------------------------------------
  logic               p1_vld_q;
  logic signed [63:0] p1_bb_q, p1_ac_q;
  logic signed [31:0] p1_a_q, p1_b_q, p1_c_q;
  logic               p1_an_q, p1_bn_q, p1_cn_q;
  logic [2:0]         p1_perm_q;
  logic               p1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (adv) begin
      p1_vld_q <= p0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_bb_q   <= p0_b_q * p0_b_q;
      p1_ac_q   <= p0_a_q * p0_c_q;
      p1_an_q   <= mag33({p0_a_q[31], p0_a_q}) < eps33;
      p1_bn_q   <= mag33({p0_b_q[31], p0_b_q}) < eps33;
      p1_cn_q   <= mag33({p0_c_q[31], p0_c_q}) < eps33;
      p1_a_q    <= p0_a_q;
      p1_b_q    <= p0_b_q;
      p1_c_q    <= p0_c_q;
      p1_perm_q <= p0_perm_q;
      p1_last_q <= p0_last_q;
    end
  end

  // ---------------------------------------------------------------------
  // P2: quarter discriminant q = b*b/4 - a*c, remainder bits of b*b.
  // ---------------------------------------------------------------------
  logic               p2_vld_q;
  logic signed [63:0] p2_q_q;
  logic [1:0]         p2_r_q;
  logic signed [31:0] p2_a_q, p2_b_q, p2_c_q;
  logic               p2_an_q, p2_bn_q, p2_cn_q;
  logic [2:0]         p2_perm_q;
  logic               p2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (adv) begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_q_q    <= (p1_bb_q >>> 2) - p1_ac_q;
      p2_r_q    <= p1_bb_q[1:0];
      p2_an_q   <= p1_an_q;
      p2_bn_q   <= p1_bn_q;
      p2_cn_q   <= p1_cn_q;
      p2_a_q    <= p1_a_q;
      p2_b_q    <= p1_b_q;
      p2_c_q    <= p1_c_q;
      p2_perm_q <= p1_perm_q;
      p2_last_q <= p1_last_q;
    end
  end

  // ---------------------------------------------------------------------
  // P3: classify; load the square-root pipeline (its stage 0).
  // ---------------------------------------------------------------------
  logic signed [63:0] d_val;
  logic signed [63:0] eps64;
  logic [2:0]         cls;
  logic [31:0]        d_sat;

  assign d_val = p2_q_q >>> (FRAC_BITS - 2);
  assign eps64 = {33'd0, eps_eff};

  always_comb begin
    if (d_val > 64'sh7fff_ffff) begin
      d_sat = 32'h7fff_ffff;
    end else if (d_val < -64'sh8000_0000) begin
      d_sat = 32'h8000_0000;
    end else begin
      d_sat = d_val[31:0];
    end
    if (p2_an_q) begin
      if (p2_bn_q) begin
        cls = p2_cn_q ? OUTC_INF : OUTC_NONE;
      end else begin
        cls = OUTC_LIN;
      end
    end else if (d_val < -eps64) begin
      cls = OUTC_NOREAL;
    end else if ((d_val > -eps64) && (d_val < eps64)) begin
      cls = OUTC_ONE;
    end else begin
      cls = OUTC_TWO;
    end
  end

  logic               sq_vld_q  [SQ_STEPS + 1];
  logic [64:0]        sq_rem_q  [SQ_STEPS + 1];
  logic [32:0]        sq_s_q    [SQ_STEPS + 1];
  logic signed [31:0] sq_a_q    [SQ_STEPS + 1];
  logic signed [31:0] sq_b_q    [SQ_STEPS + 1];
  logic signed [31:0] sq_c_q    [SQ_STEPS + 1];
  qrs_ctx_t           sq_ctx_q  [SQ_STEPS + 1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else if (adv) begin
      sq_vld_q[0] <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Negative exact discriminant: root taken as zero.
      sq_rem_q[0]      <= p2_q_q[63] ? 65'd0 : {p2_q_q[62:0], p2_r_q};
      sq_s_q[0]        <= '0;
      sq_a_q[0]        <= p2_a_q;
      sq_b_q[0]        <= p2_b_q;
      sq_c_q[0]        <= p2_c_q;
      sq_ctx_q[0].perm <= p2_perm_q;
      sq_ctx_q[0].last <= p2_last_q;
      sq_ctx_q[0].outc <= cls;
      sq_ctx_q[0].disc <= ((cls == OUTC_NOREAL) || (cls == OUTC_ONE) || (cls == OUTC_TWO))
                          ? d_sat : 32'd0;
    end
  end

  // One root bit per stage, most significant first: keep rem = E - s*s.
  for (genvar gi = 0; gi < SQ_STEPS; gi++) begin : g_sqrt
    localparam int K = SQ_STEPS - 1 - gi;
    logic [66:0] trial;
    logic        take;

    assign trial = ({34'd0, sq_s_q[gi]} << (K + 1)) | (67'd1 << (2 * K));
    assign take  = {2'b00, sq_rem_q[gi]} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[gi + 1] <= 1'b0;
      end else if (adv) begin
        sq_vld_q[gi + 1] <= sq_vld_q[gi];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[gi + 1] <= take ? 65'({2'b00, sq_rem_q[gi]} - trial) : sq_rem_q[gi];
        sq_s_q[gi + 1]   <= take ? (sq_s_q[gi] | (33'd1 << K)) : sq_s_q[gi];
        sq_a_q[gi + 1]   <= sq_a_q[gi];
        sq_b_q[gi + 1]   <= sq_b_q[gi];
        sq_c_q[gi + 1]   <= sq_c_q[gi];
        sq_ctx_q[gi + 1] <= sq_ctx_q[gi];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Form numerators and the shared denominator; load the dividers.
  // ---------------------------------------------------------------------
  qrs_ctx_t           fc;
  logic               f_lin;
  logic [33:0]        f_s;
  logic signed [34:0] f_nb, f_num1, f_num2;
  logic signed [32:0] f_den;
  logic [34:0]        f_mag1, f_mag2;
  logic [32:0]        f_dmag;

  assign fc     = sq_ctx_q[SQ_STEPS];
  assign f_lin  = fc.outc == OUTC_LIN;
  assign f_s    = (fc.outc == OUTC_TWO) ? {1'b0, sq_s_q[SQ_STEPS]} : 34'd0;
  assign f_nb   = -{{3{sq_b_q[SQ_STEPS][31]}}, sq_b_q[SQ_STEPS]};
  assign f_num1 = f_lin ? -{{3{sq_c_q[SQ_STEPS][31]}}, sq_c_q[SQ_STEPS]}
                        : f_nb + {1'b0, f_s};
  assign f_num2 = f_nb - {1'b0, f_s};
  assign f_den  = f_lin ? {sq_b_q[SQ_STEPS][31], sq_b_q[SQ_STEPS]}
                        : {sq_a_q[SQ_STEPS], 1'b0};
  assign f_mag1 = f_num1[34] ? (~f_num1 + 35'd1) : f_num1;
  assign f_mag2 = f_num2[34] ? (~f_num2 + 35'd1) : f_num2;
  assign f_dmag = mag33(f_den);

  logic          dv_vld_q  [NM + 1];
  logic [32:0]   dv_dmag_q [NM + 1];
  logic [32:0]   dv_r1_q   [NM + 1];
  logic [32:0]   dv_r2_q   [NM + 1];
  logic [NM-1:0] dv_w1_q   [NM + 1];
  logic [NM-1:0] dv_w2_q   [NM + 1];
  logic          dv_n1_q   [NM + 1];
  logic          dv_n2_q   [NM + 1];
  qrs_ctx_t      dv_ctx_q  [NM + 1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_q[0] <= sq_vld_q[SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_dmag_q[0] <= f_dmag;
      dv_r1_q[0]   <= '0;
      dv_r2_q[0]   <= '0;
      dv_w1_q[0]   <= {f_mag1[33:0], {FRAC_BITS{1'b0}}};
      dv_w2_q[0]   <= {f_mag2[33:0], {FRAC_BITS{1'b0}}};
      dv_n1_q[0]   <= f_num1[34] ^ f_den[32];
      dv_n2_q[0]   <= f_num2[34] ^ f_den[32];
      dv_ctx_q[0]  <= fc;
    end
  end

  // Restoring division, one quotient bit per stage for both roots.
  // Dividend bits shift out of the top of w while quotient bits enter below.
  for (genvar gj = 0; gj < NM; gj++) begin : g_div
    logic [33:0] t1, t2;
    logic        ge1, ge2;

    assign t1  = {dv_r1_q[gj], dv_w1_q[gj][NM-1]};
    assign t2  = {dv_r2_q[gj], dv_w2_q[gj][NM-1]};
    assign ge1 = t1 >= {1'b0, dv_dmag_q[gj]};
    assign ge2 = t2 >= {1'b0, dv_dmag_q[gj]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[gj + 1] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[gj + 1] <= dv_vld_q[gj];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_r1_q[gj + 1]   <= ge1 ? 33'(t1 - {1'b0, dv_dmag_q[gj]}) : t1[32:0];
        dv_r2_q[gj + 1]   <= ge2 ? 33'(t2 - {1'b0, dv_dmag_q[gj]}) : t2[32:0];
        dv_w1_q[gj + 1]   <= {dv_w1_q[gj][NM-2:0], ge1};
        dv_w2_q[gj + 1]   <= {dv_w2_q[gj][NM-2:0], ge2};
        dv_dmag_q[gj + 1] <= dv_dmag_q[gj];
        dv_n1_q[gj + 1]   <= dv_n1_q[gj];
        dv_n2_q[gj + 1]   <= dv_n2_q[gj];
        dv_ctx_q[gj + 1]  <= dv_ctx_q[gj];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Fin: signed quotients and their difference.
  // ---------------------------------------------------------------------
  logic signed [NM:0]   g_q1, g_q2;
  logic                 fin_vld_q;
  logic signed [NM:0]   fin_q1_q, fin_q2_q;
  logic signed [NM+1:0] fin_df_q;
  qrs_ctx_t             fin_ctx_q;

  assign g_q1 = dv_n1_q[NM] ? -$signed({1'b0, dv_w1_q[NM]}) : $signed({1'b0, dv_w1_q[NM]});
  assign g_q2 = dv_n2_q[NM] ? -$signed({1'b0, dv_w2_q[NM]}) : $signed({1'b0, dv_w2_q[NM]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
    end else if (adv) begin
      fin_vld_q <= dv_vld_q[NM];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fin_q1_q  <= g_q1;
      fin_q2_q  <= g_q2;
      fin_df_q  <= {g_q1[NM], g_q1} - {g_q2[NM], g_q2};
      fin_ctx_q <= dv_ctx_q[NM];
    end
  end

  // ---------------------------------------------------------------------
  // Output register: merge near roots, saturate, drop unused fields.
  // ---------------------------------------------------------------------
  logic [NM+1:0] df_mag;
  logic          roots_near;
  logic [2:0]    o_outc;
  logic [2:0]    out_perm_q, out_outc_q;
  logic [31:0]   out_r1_q, out_r2_q, out_disc_q;
  logic          out_last_q;

  assign df_mag     = fin_df_q[NM+1] ? (~fin_df_q + 1'b1) : fin_df_q;
  assign roots_near = df_mag < {{(NM - 29){1'b0}}, eps_eff};
  assign o_outc     = ((fin_ctx_q.outc == OUTC_TWO) && roots_near) ? OUTC_ONE
                                                                  : fin_ctx_q.outc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= fin_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_perm_q <= fin_ctx_q.perm;
      out_outc_q <= o_outc;
      out_last_q <= fin_ctx_q.last;
      out_disc_q <= fin_ctx_q.disc;
      out_r1_q   <= ((o_outc == OUTC_LIN) || (o_outc == OUTC_ONE) || (o_outc == OUTC_TWO))
                    ? sat_q(fin_q1_q) : 32'd0;
      out_r2_q   <= (o_outc == OUTC_TWO) ? sat_q(fin_q2_q) : 32'd0;
    end
  end

  assign out_m.valid        = out_vld_q;
  assign out_m.perm_index   = out_perm_q;
  assign out_m.outcome      = out_outc_q;
  assign out_m.root_one     = out_r1_q;
  assign out_m.root_two     = out_r2_q;
  assign out_m.discriminant = out_disc_q;
  assign out_m.last         = out_last_q;

endmodule

// File: hdl/qrs_chk.sv
// qrs_chk: port-level checks on the solver's result channel, bound to
// quadratic_root_solver_permutations. Uses qrs_pkg.
module qrs_chk
  import qrs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  perm_index_i,
  input logic [2:0]  outcome_i,
  input logic [31:0] root_one_i,
  input logic [31:0] root_two_i,
  input logic [31:0] discriminant_i,
  input logic        last_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(perm_index_i)
      && $stable(outcome_i) && $stable(root_one_i) && $stable(last_i))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (perm_index_i <= PERM_LAST) && (outcome_i <= OUTC_TWO))
    else $error("ordering or outcome code out of range");

  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((outcome_i == OUTC_INF) || (outcome_i == OUTC_NONE))
      |-> (root_one_i == '0) && (root_two_i == '0) && (discriminant_i == '0))
    else $error("degenerate case carries roots or discriminant");

  a_noreal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (outcome_i == OUTC_NOREAL)
      |-> discriminant_i[31] && (root_one_i == '0) && (root_two_i == '0))
    else $error("no-real-roots case inconsistent");

endmodule

bind quadratic_root_solver_permutations qrs_chk u_qrs_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_m.valid),
  .out_ready_i    (out_m.ready),
  .perm_index_i   (out_m.perm_index),
  .outcome_i      (out_m.outcome),
  .root_one_i     (out_m.root_one),
  .root_two_i     (out_m.root_two),
  .discriminant_i (out_m.discriminant),
  .last_i         (out_m.last)
);

// File: verif/testbench.sv
// Self-checking testbench for quadratic_root_solver_permutations.
// Directed table, then random coefficient triples, predicted in place.
// Needs qrs_pkg (hdl/qrs_pkg.sv) and the channel interfaces (hdl/qrs_if.sv).
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qrs_pkg::*;

  localparam int  FRAC       = 16;
  localparam int  IDLE_LIMIT = 6000;   // cycles without any transaction
  localparam int  DRAIN_WAIT = 200;    // quiet time after the last result
  localparam int  RAND_ITEMS = 64;     // random items per epsilon phase

  // One expected result of one surviving ordering.
  typedef struct packed {
    logic [2:0]         perm;
    logic [2:0]         outc;
    logic signed [31:0] root_a;
    logic signed [31:0] root_b;
    logic signed [31:0] disc;
    logic               last;
  } root_rec_t;

  // Directed stimulus row; typed rows carry their single result inline.
  typedef struct {
    logic signed [31:0] f;
    logic signed [31:0] s;
    logic signed [31:0] t;
    bit                 typed;
    logic [2:0]         outc;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [30:0] cfg_wdata;

  qrs_in_if  in_ch();
  qrs_out_if out_ch();

  quadratic_root_solver_permutations dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_s        (in_ch),
    .out_m       (out_ch)
  );

  // Our own copy of the tolerance register and of the ordering table.
  logic [30:0] eps_reg;
  int unsigned order_tab [6][3] = '{'{0, 1, 2}, '{0, 2, 1}, '{1, 0, 2},
                                    '{1, 2, 0}, '{2, 0, 1}, '{2, 1, 0}};

  root_rec_t pending_roots_q[$];
  int        mismatches;
  int        items_sent;
  int        results_seen;
  int        outc_hits [6];
  int        tx_idle_pct;
  int        rx_idle_pct;
  int        quiet_cycles;
  bit        run_done;

  // Clock: 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -longint'(64'h80000000)) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Fixed-point quotient, truncated toward zero.
  function automatic longint fx_quot(longint num, longint den);
    return (num * (longint'(1) << FRAC)) / den;
  endfunction

  // Classify a*x^2 + b*x + c and compute its roots for one ordering.
  function automatic root_rec_t solve_ordering(longint eps, longint a, longint b,
                                               longint c, logic [2:0] p);
    root_rec_t          r;
    logic signed [127:0] aw, bw, cw, ee, sq, cand;
    longint             d, x1, x2, s;
    r        = '0;
    r.perm   = p;
    if (mag(a) < eps) begin
      if (mag(b) < eps) begin
        r.outc = (mag(c) < eps) ? OUTC_INF : OUTC_NONE;
      end else begin
        r.outc   = OUTC_LIN;
        r.root_a = clamp32(fx_quot(-c, b));
      end
      return r;
    end
    aw = a;
    bw = b;
    cw = c;
    // Exact discriminant carries 2*FRAC fraction bits; report it floored.
    ee = bw * bw - 4 * aw * cw;
    d  = longint'(ee >>> FRAC);
    r.disc = clamp32(d);
    if (d < -eps) begin
      r.outc = OUTC_NOREAL;
    end else if (mag(d) < eps) begin
      r.outc   = OUTC_ONE;
      r.root_a = clamp32(fx_quot(-b, 2 * a));
    end else begin
      sq = 0;
      if (ee > 0) begin
        for (int bt = 32; bt >= 0; bt--) begin
          cand = sq | (128'sd1 << bt);
          if (cand * cand <= ee) sq = cand;
        end
      end
      s  = longint'(sq);
      x1 = fx_quot(-b + s, 2 * a);
      x2 = fx_quot(-b - s, 2 * a);
      r.root_a = clamp32(x1);
      if (mag(x1 - x2) < eps) begin
        r.outc = OUTC_ONE;
      end else begin
        r.outc   = OUTC_TWO;
        r.root_b = clamp32(x2);
      end
    end
    return r;
  endfunction

  // Queue the results of one accepted triple; near-duplicate orderings drop out.
  function automatic void predict_triple(logic signed [31:0] f, logic signed [31:0] s,
                                         logic signed [31:0] t);
    longint    v [3];
    longint    eps;
    bit        drop [6];
    bit        near;
    root_rec_t rec [$];
    eps  = (eps_reg == 0) ? 1 : longint'(eps_reg);
    v[0] = f;
    v[1] = s;
    v[2] = t;
    drop = '{default: 1'b0};
    for (int i = 0; i < 6; i++) begin
      if (!drop[i]) begin
        for (int j = i + 1; j < 6; j++) begin
          near = 1'b1;
          for (int k = 0; k < 3; k++) begin
            if (mag(v[order_tab[i][k]] - v[order_tab[j][k]]) >= eps) near = 1'b0;
          end
          if (near) drop[j] = 1'b1;
        end
        rec.push_back(solve_ordering(eps, v[order_tab[i][0]], v[order_tab[i][1]],
                                     v[order_tab[i][2]], 3'(i)));
      end
    end
    rec[rec.size() - 1].last = 1'b1;
    foreach (rec[n]) pending_roots_q.push_back(rec[n]);
  endfunction

  // ---------------------------------------------------------------------------
  // Random coefficients
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] rand_num();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return (int'($urandom_range(0, 20)) - 10) <<< FRAC;
      2:       return int'($urandom_range(0, 2000000)) - 1000000;
      3:       return int'($urandom_range(0, 400)) - 200;
      4: begin
        case ($urandom_range(0, 4))
          0:       return 32'sh7fffffff;
          1:       return 32'sh80000000;
          2:       return 32'sd1;
          3:       return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return 32'sd0;
    endcase
  endfunction

  // Well-formed quadratics with integer roots, plus near-equal triples and noise.
  task automatic rand_triple(output logic signed [31:0] f, output logic signed [31:0] s,
                             output logic signed [31:0] t);
    int k, m, n, base;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        k = int'($urandom_range(1, 3)) * ($urandom_range(0, 1) ? 1 : -1);
        m = int'($urandom_range(0, 16)) - 8;
        n = $urandom_range(0, 3) == 0 ? m : int'($urandom_range(0, 16)) - 8;
        f = k <<< FRAC;
        s = (-(m + n) * k) <<< FRAC;
        t = (m * n * k) <<< FRAC;
      end
      4, 5: begin
        base = $urandom;
        f = base;
        s = base + int'($urandom_range(0, 200)) - 100;
        t = $urandom_range(0, 1) ? base : base + int'($urandom_range(0, 200)) - 100;
      end
      default: begin
        f = rand_num();
        s = rand_num();
        t = rand_num();
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Present one transaction at a falling edge and hold it until accepted.
  task automatic push_triple(logic signed [31:0] f, logic signed [31:0] s,
                             logic signed [31:0] t);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.coef_first  <= f;
    in_ch.coef_second <= s;
    in_ch.coef_third  <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_triple(f, s, t);
    items_sent++;
  endtask

  // Drop valid and hold until every queued result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_roots_q.size() != 0) @(negedge clk);
  endtask

  // Write epsilon while the solver is empty.
  task automatic write_eps(logic [30:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    eps_reg    = val;
  endtask

  // Receiver: stall at random, decided at each falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    root_rec_t want;
    root_rec_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.perm_index, out_ch.outcome, out_ch.root_one, out_ch.root_two,
              out_ch.discriminant, out_ch.last};
      results_seen++;
      if (pending_roots_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result perm=%0d outcome=%0d", got.perm, got.outc);
      end else begin
        want = pending_roots_q.pop_front();
        if (want.outc < 6) outc_hits[want.outc]++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: perm exp %0d got %0d, outcome exp %0d got %0d, ",
                      "root_one exp %0d got %0d, root_two exp %0d got %0d, ",
                      "disc exp %0d got %0d, last exp %0b got %0b"},
                     want.perm, got.perm, want.outc, got.outc, want.root_a, got.root_a,
                     want.root_b, got.root_b, want.disc, got.disc, want.last, got.last);
        end
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if (!rst_n || run_done || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  stim_row_t dir_tab [] = '{
    // all zero: every ordering collapses onto the first, infinite solutions
    '{32'sd0, 32'sd0, 32'sd0, 1'b1, OUTC_INF},
    // all below epsilon: same collapse
    '{32'sd1, 32'sd1, 32'sd1, 1'b1, OUTC_INF},
    // range extremes and saturation
    '{32'sh80000000, 32'sh7fffffff, 32'sd0, 1'b0, 3'd0},
    '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0, 3'd0},
    '{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, 3'd0},
    '{32'sd100, 32'sh7fffffff, 32'sd0, 1'b0, 3'd0},
    '{32'sh80000000, 32'sd0, 32'sh7fffffff, 1'b0, 3'd0},
    // linear, none, no real roots, double root, two roots
    '{32'sd0, 32'sh00020000, 32'sh00040000, 1'b0, 3'd0},
    '{32'sd0, 32'sd0, 32'sh00050000, 1'b0, 3'd0},
    '{32'sh00010000, 32'sd0, 32'sh00010000, 1'b0, 3'd0},
    '{32'sh00010000, -32'sh00020000, 32'sh00010000, 1'b0, 3'd0},
    '{32'sh00010000, -32'sh00030000, 32'sh00020000, 1'b0, 3'd0},
    // discriminant just above zero, and roots close together
    '{32'sh00010000, 32'sd0, -32'sd1, 1'b0, 3'd0},
    '{32'sh40000000, 32'sd0, -32'sd1, 1'b0, 3'd0},
    '{32'sh00010000, 32'sd0, -32'sh00640000, 1'b0, 3'd0},
    // two given numbers nearly equal: some orderings drop out
    '{32'sh00030000, 32'sh00030010, -32'sh00010000, 1'b0, 3'd0}
  };

  initial begin
    logic signed [31:0] f, s, t;
    logic [30:0]        eps_plan [5];
    root_rec_t          fixed_rec;
    in_ch.valid       = 1'b0;
    in_ch.coef_first  = '0;
    in_ch.coef_second = '0;
    in_ch.coef_third  = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    eps_reg           = EPS_RESET;
    mismatches        = 0;
    items_sent        = 0;
    results_seen      = 0;
    outc_hits         = '{default: 0};
    run_done          = 1'b0;
    tx_idle_pct       = 29;
    rx_idle_pct       = 62;
    rst_n             = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table at the reset tolerance.
    foreach (dir_tab[r]) begin
      if (dir_tab[r].typed) begin
        push_triple(dir_tab[r].f, dir_tab[r].s, dir_tab[r].t);
        // Replace the predicted entry with the one read straight off the row.
        void'(pending_roots_q.pop_back());
        fixed_rec      = '0;
        fixed_rec.outc = dir_tab[r].outc;
        fixed_rec.last = 1'b1;
        pending_roots_q.push_back(fixed_rec);
      end else begin
        push_triple(dir_tab[r].f, dir_tab[r].s, dir_tab[r].t);
      end
    end

    // Random phases, each at its own tolerance, including both extremes.
    eps_plan = '{EPS_RESET, 31'd0, 31'h7fffffff, 31'($urandom_range(1, 65536)), 31'd1};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) write_eps(eps_plan[ph]);
      if (ph == 2) begin
        tx_idle_pct = 62;
        rx_idle_pct = 29;
      end else if (ph == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int n = 0; n < RAND_ITEMS; n++) begin
        // Hold off once mid-phase until the solver has fully emptied.
        if (ph == 1 && n == RAND_ITEMS / 2) drain_results();
        rand_triple(f, s, t);
        push_triple(f, s, t);
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_roots_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    run_done = 1'b1;

    $display("Covered %0d triples over five tolerances, %0d results checked.",
             items_sent, results_seen);
    $display("Outcomes inf/none/lin/noreal/one/two: %0d/%0d/%0d/%0d/%0d/%0d, mismatches %0d",
             outc_hits[0], outc_hits[1], outc_hits[2], outc_hits[3], outc_hits[4],
             outc_hits[5], mismatches);
    if (mismatches == 0 && pending_roots_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
